// ===== hdl/bafs_pkg.sv =====
// Package for the bracket-aware field splitter.
// Holds byte codes, status codes, register indexes and fixed widths.
// No dependencies.
package bafs_pkg;

   localparam int CHAR_W     = 8;
   localparam int INDEX_W    = 4;
   localparam int START_W    = 10;
   localparam int LENGTH_W   = 6;
   localparam int FIELDS_W   = 5;
   localparam int DEPTH_W    = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_LBRACK = 8'h5B;
   localparam logic [CHAR_W-1:0] CHAR_RBRACK = 8'h5D;

   localparam logic [DEPTH_W-1:0]  DEPTH_MAX    = 10'd1023;
   localparam logic [FIELDS_W-1:0] FIELDS_MAX   = 5'd31;
   localparam logic [INDEX_W-1:0]  INDEX_MAX    = 4'd15;

   localparam logic [CHAR_W-1:0]   SEPARATOR_RST  = 8'd44;
   localparam logic [FIELDS_W-1:0] MAX_FIELDS_RST = 5'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEPARATOR  = 2'd0,
      CSR_MAX_FIELDS = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_MANY  = 2'd1,
      STATUS_TOO_LONG  = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

endpackage

// ===== hdl/bracket_aware_field_splitter.sv =====
// Bracket-aware field splitter: top level, single module.
// Depends on bafs_pkg.
//
// Usage:
//   Text bytes arrive on the req_ channel (req_valid / req_stall / req_character),
//   one byte per request; a zero byte terminates the text. Each separator byte
//   at bracket depth zero, and the terminator, closes a field and yields one
//   result on the rsp_ channel: field index, start and length (trimmed if OK), status
//   and a last flag. Other bytes yield no result. After an error the rest of
//   the text up to the terminator is dropped silently.
//   The csr_ channel (always ready) writes the separator (index 0) and the
//   field limit (index 1); write only while the block is idle.
//   An accepted request passes through the input register, then the result register.
//   Throughput: one byte per cycle while rsp_stall is low, set by the single state update stage.
//   Reset (synchronous, active high) clears the text state, restores the
//   register defaults and empties both pipeline registers.
//   When rsp_stall holds a result, the input register fills and req_stall
//   rises in the same cycle; nothing is lost or repeated.
module bracket_aware_field_splitter
   import bafs_pkg::*;
#(
   parameter int MAX_FIELDS  = 16,
   parameter int FIELD_LIMIT = 64,
   parameter int TEXT_LIMIT  = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_character,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [INDEX_W-1:0]    rsp_field_index,
   output logic [START_W-1:0]    rsp_field_start,
   output logic [LENGTH_W-1:0]   rsp_field_length,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int POS_W = $clog2(TEXT_LIMIT);
   localparam int CMP_W = POS_W + 9;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(TEXT_LIMIT - 1);
   localparam logic [CMP_W-1:0] FIELD_LIMIT_C = CMP_W'(FIELD_LIMIT);

   // configuration
   logic [CHAR_W-1:0]   separator_ff;
   logic [FIELDS_W-1:0] max_fields_ff;

   // input register
   logic                in_valid_ff;
   logic [CHAR_W-1:0]   in_char_ff;

   // text state
   logic [POS_W-1:0]    position_ff, position_in;
   logic [POS_W-1:0]    field_begin_ff, field_begin_in;
   logic [POS_W-1:0]    first_nb_ff, first_nb_in;
   logic [POS_W-1:0]    last_nb_ff, last_nb_in;
   logic                seen_nb_ff, seen_nb_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [FIELDS_W-1:0] fields_done_ff, fields_done_in;
   logic                discarding_ff, discarding_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [START_W-1:0]  start_ff, start_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   status_type          status_ff, status_in;
   logic                last_ff, last_in;

   logic                advance;
   logic [DEPTH_W-1:0]  depth_nx;
   logic                closes;
   logic                is_blank;
   logic [POS_W-1:0]    pos_inc;
   logic [POS_W-1:0]    raw_len;
   logic                limit_hit;
   logic                too_long;
   logic [POS_W-1:0]    trim_len;
   logic [CMP_W-1:0]    begin_wide;
   logic [CMP_W-1:0]    first_wide;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_field_index  = index_ff;
   assign rsp_field_start  = start_ff;
   assign rsp_field_length = length_ff;
   assign rsp_status       = status_ff;
   assign rsp_last         = last_ff;

   always_comb begin
      depth_nx = depth_ff;
      if (in_char_ff == CHAR_LPAREN || in_char_ff == CHAR_LBRACK) begin
         if (depth_ff < DEPTH_MAX) depth_nx = depth_ff + 1'b1;
      end else if ((in_char_ff == CHAR_RPAREN || in_char_ff == CHAR_RBRACK)
                   && depth_ff != '0) begin
         depth_nx = depth_ff - 1'b1;
      end
      closes    = (in_char_ff == separator_ff && depth_nx == '0) || in_char_ff == CHAR_NUL;
      is_blank  = in_char_ff == CHAR_SPACE || in_char_ff == CHAR_TAB;
      pos_inc   = (position_ff < POS_MAX) ? position_ff + 1'b1 : position_ff;
      raw_len   = (position_ff >= field_begin_ff) ? position_ff - field_begin_ff : '0;
      limit_hit = ({1'b0, fields_done_ff} >= {1'b0, max_fields_ff})
                  || (int'(fields_done_ff) >= MAX_FIELDS);
      too_long  = {9'b0, raw_len} >= FIELD_LIMIT_C;
      trim_len  = last_nb_ff - first_nb_ff + 1'b1;
      begin_wide = {9'b0, field_begin_ff};
      first_wide = {9'b0, first_nb_ff};
   end

   always_comb begin
      position_in    = position_ff;
      field_begin_in = field_begin_ff;
      first_nb_in    = first_nb_ff;
      last_nb_in     = last_nb_ff;
      seen_nb_in     = seen_nb_ff;
      depth_in       = depth_ff;
      fields_done_in = fields_done_ff;
      discarding_in  = discarding_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      index_in       = index_ff;
      start_in       = start_ff;
      length_in      = length_ff;
      status_in      = status_ff;
      last_in        = last_ff;

      if (advance) begin
         rsp_valid_in = 1'b0;
         if (discarding_ff) begin
            if (in_char_ff == CHAR_NUL) begin
               position_in    = '0;
               field_begin_in = '0;
               first_nb_in    = '0;
               last_nb_in     = '0;
               seen_nb_in     = 1'b0;
               depth_in       = '0;
               fields_done_in = '0;
               discarding_in  = 1'b0;
            end else begin
               position_in = pos_inc;
            end
         end else if (!closes) begin
            depth_in = depth_nx;
            if (!is_blank) begin
               if (!seen_nb_ff) begin
                  first_nb_in = position_ff;
                  seen_nb_in  = 1'b1;
               end
               last_nb_in = position_ff;
            end
            position_in = pos_inc;
         end else begin
            depth_in     = depth_nx;
            rsp_valid_in = 1'b1;
            if (limit_hit || too_long || !seen_nb_ff) begin
               if (limit_hit)     status_in = STATUS_TOO_MANY;
               else if (too_long) status_in = STATUS_TOO_LONG;
               else               status_in = STATUS_EMPTY;
               index_in  = (fields_done_ff > FIELDS_W'(INDEX_MAX)) ? INDEX_MAX
                                                                   : fields_done_ff[INDEX_W-1:0];
               start_in  = begin_wide[START_W-1:0];
               length_in = '0;
               last_in   = 1'b1;
               if (in_char_ff != CHAR_NUL) begin
                  discarding_in = 1'b1;
                  position_in   = pos_inc;
               end
            end else begin
               status_in = STATUS_OK;
               index_in  = fields_done_ff[INDEX_W-1:0];
               start_in  = first_wide[START_W-1:0];
               length_in = trim_len[LENGTH_W-1:0];
               last_in   = in_char_ff == CHAR_NUL;
               if (in_char_ff != CHAR_NUL) begin
                  if (fields_done_ff < FIELDS_MAX) fields_done_in = fields_done_ff + 1'b1;
                  field_begin_in = pos_inc;
                  seen_nb_in     = 1'b0;
                  first_nb_in    = '0;
                  last_nb_in     = '0;
                  position_in    = pos_inc;
               end
            end
            if (in_char_ff == CHAR_NUL) begin
               position_in    = '0;
               field_begin_in = '0;
               first_nb_in    = '0;
               last_nb_in     = '0;
               seen_nb_in     = 1'b0;
               depth_in       = '0;
               fields_done_in = '0;
               discarding_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff   <= SEPARATOR_RST;
         max_fields_ff  <= MAX_FIELDS_RST;
         in_valid_ff    <= 1'b0;
         position_ff    <= '0;
         field_begin_ff <= '0;
         first_nb_ff    <= '0;
         last_nb_ff     <= '0;
         seen_nb_ff     <= 1'b0;
         depth_ff       <= '0;
         fields_done_ff <= '0;
         discarding_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SEPARATOR:  separator_ff  <= csr_data;
               CSR_MAX_FIELDS: max_fields_ff <= csr_data[FIELDS_W-1:0];
               default: ;
            endcase
         end
         if (!req_stall) in_valid_ff <= req_valid;
         position_ff    <= position_in;
         field_begin_ff <= field_begin_in;
         first_nb_ff    <= first_nb_in;
         last_nb_ff     <= last_nb_in;
         seen_nb_ff     <= seen_nb_in;
         depth_ff       <= depth_in;
         fields_done_ff <= fields_done_in;
         discarding_ff  <= discarding_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_char_ff <= req_character;
      index_ff  <= index_in;
      start_ff  <= start_in;
      length_ff <= length_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

endmodule
